// File: src/c1sc_pkg.sv
// Shared types, constants and step functions for the Crypto1 candidate checker.
// No dependencies; every other file in src imports this package.
package c1sc_pkg;

    localparam int unsigned STEPS_PER_WORD = 32;
    localparam int unsigned N_WORDS        = 6;
    localparam int unsigned N_CELLS        = STEPS_PER_WORD * N_WORDS;

    localparam logic [23:0] POLY_ODD  = 24'h29CE5C;
    localparam logic [23:0] POLY_EVEN = 24'h870804;

    localparam logic [19:0] NLF_A = 20'hF22C0;
    localparam logic [19:0] NLF_B = 20'h6C9C0;
    localparam logic [19:0] NLF_C = 20'h3C8B0;
    localparam logic [19:0] NLF_D = 20'h1E458;
    localparam logic [19:0] NLF_E = 20'h0D938;
    localparam logic [31:0] NLF_F = 32'hEC57E80A;

    typedef enum logic [2:0] {
        CFG_ATTACK_MODE          = 3'd0,
        CFG_READER_NONCE0_ENC    = 3'd1,
        CFG_UID_XOR_TAG_NONCE0   = 3'd2,
        CFG_UID_XOR_TAG_NONCE1   = 3'd3,
        CFG_READER_NONCE1_ENC    = 3'd4,
        CFG_READER_ANSWER1_ENC   = 3'd5,
        CFG_TAG_NONCE1_SUCC64    = 3'd6,
        CFG_NESTED_KEYSTREAM_ENC = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        MODE_TWO_SESSION = 1'b0,
        MODE_NESTED      = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        OP_HOLD = 2'b00,
        OP_BACK = 2'b01,
        OP_FWD  = 2'b10
    } t_op;

    // What one cell does to the request passing through it
    typedef struct packed {
        t_op  op;
        logic in_bit;
        logic fb;
        logic keep;
        logic ks_en;
    } t_cell_ctl;

    // Payload carried along the chain
    typedef struct packed {
        logic        nz;
        logic [23:0] o;
        logic [23:0] e;
        logic [23:0] ko;
        logic [23:0] ke;
        logic [31:0] ks;
    } t_stage;

    typedef struct packed {
        logic        match;
        logic [47:0] key;
    } t_result;

    // Nonlinear output filter over state bits 0..19
    function automatic logic nlf(input logic [23:0] v);
        logic [19:0] ta;
        logic [19:0] tb;
        logic [19:0] tc;
        logic [19:0] td;
        logic [19:0] te;
        logic [4:0]  idx;
        ta = NLF_A >> v[3:0];
        tb = NLF_B >> v[7:4];
        tc = NLF_C >> v[11:8];
        td = NLF_D >> v[15:12];
        te = NLF_E >> v[19:16];
        idx = {ta[4], tb[3], tc[2], td[1], te[0]};
        return NLF_F[idx];
    endfunction

    // Shift-in order to word order: step j lands at word bit j^24
    function automatic logic [31:0] ks_order(input logic [31:0] sh);
        logic [31:0] w;
        for (int j = 0; j < 32; j++) begin
            w[5'(j) ^ 5'd24] = sh[5'(31 - j)];
        end
        return w;
    endfunction

    // Interleave halves into the key, first key byte on top
    function automatic logic [47:0] pack_key(input logic [23:0] o, input logic [23:0] e);
        logic [47:0] k;
        for (int i = 0; i < 24; i++) begin
            k[2 * i + 1] = o[5'(i) ^ 5'd3];
            k[2 * i]     = e[5'(i) ^ 5'd3];
        end
        return k;
    endfunction

endpackage

// File: src/c1sc_cell.sv
// One cell of the cipher chain: a single backward or forward register step, or a hold.
// Depends on c1sc_pkg (step functions, t_stage, t_cell_ctl).
module c1sc_cell import c1sc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_stage    i_data,
    input  t_cell_ctl i_ctl,
    output logic      o_valid,
    output t_stage    o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic   fbit;
    logic   ks_bit;

    always_comb begin
        n_data = i_data;
        fbit   = 1'b0;
        ks_bit = 1'b0;
        unique case (i_ctl.op)
            OP_BACK: begin
                fbit = (nlf(i_data.e) & i_ctl.fb) ^ i_data.o[0]
                     ^ (^(POLY_EVEN & {1'b0, i_data.o[23:1]}))
                     ^ (^(POLY_ODD & i_data.e)) ^ i_ctl.in_bit;
                n_data.o = i_data.e;
                n_data.e = {fbit, i_data.o[23:1]};
            end
            OP_FWD: begin
                ks_bit = nlf(i_data.o);
                fbit = (ks_bit & i_ctl.fb) ^ (^(POLY_EVEN & i_data.e))
                     ^ (^(POLY_ODD & i_data.o)) ^ i_ctl.in_bit;
                n_data.o = {i_data.e[22:0], fbit};
                n_data.e = i_data.o;
            end
            default: begin
                n_data = i_data;
            end
        endcase
        if (i_ctl.keep) begin
            n_data.ko = n_data.o;
            n_data.ke = n_data.e;
        end
        if (i_ctl.ks_en) begin
            n_data.ks = {i_data.ks[30:0], ks_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/c1sc_out.sv
// Output register with a one-entry skid stage behind it.
// Depends on c1sc_pkg (t_result).
module c1sc_out import c1sc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    load_out;

    // Output register is free when empty or being taken
    assign load_out = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (!load_out && i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_room   = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: src/crypto1_candidate_state_checker_unit.sv
// Top level of the Crypto1 candidate-state checker: config registers, cell chain, output.
// Depends on c1sc_pkg, c1sc_cell and c1sc_out.
//
// Usage
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): write the
//   attack mode and the captured nonces while no request is in flight. o_cfg_ready
//   is always high; a write lands at the clock edge where i_cfg_valid is high.
//   Input channel (i_in_valid / o_in_ready): one request is one candidate state,
//   odd and even halves. Output channel (o_out_valid / i_out_ready): one result per
//   request, in order, with o_match and the packed key (zero when there is no match).
//   Throughput: one request per cycle while o_in_ready is high. Each request walks
//   a chain of 192 cells, one register step per cell (three words back, then three
//   forward); the nested mode uses the first 64 cells and lets the request ride
//   through the rest, so both modes take the same path to the output register.
//   Stall: the output register is backed by a one-entry skid stage; the chain keeps
//   taking requests while a result waits, and freezes as a whole only once the skid
//   stage is full, dropping o_in_ready until the receiver takes a result.
//   Reset: synchronous, active low; clears all config registers to zero and empties
//   the chain and the output stages.
module crypto1_candidate_state_checker_unit import c1sc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // candidate requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_cand_odd,
    input  logic [31:0] i_cand_even,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_match,
    output logic [47:0] o_key_value
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_mode       r_mode;
    logic [31:0] r_rn0_enc;
    logic [31:0] r_nt0_x;
    logic [31:0] r_nt1_x;
    logic [31:0] r_rn1_enc;
    logic [31:0] r_ra1_enc;
    logic [31:0] r_nt1_succ;
    logic [31:0] r_nested_ks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TWO_SESSION;
            r_rn0_enc   <= '0;
            r_nt0_x     <= '0;
            r_nt1_x     <= '0;
            r_rn1_enc   <= '0;
            r_ra1_enc   <= '0;
            r_nt1_succ  <= '0;
            r_nested_ks <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACK_MODE:          r_mode      <= t_mode'(i_cfg_data[0]);
                CFG_READER_NONCE0_ENC:    r_rn0_enc   <= i_cfg_data;
                CFG_UID_XOR_TAG_NONCE0:   r_nt0_x     <= i_cfg_data;
                CFG_UID_XOR_TAG_NONCE1:   r_nt1_x     <= i_cfg_data;
                CFG_READER_NONCE1_ENC:    r_rn1_enc   <= i_cfg_data;
                CFG_READER_ANSWER1_ENC:   r_ra1_enc   <= i_cfg_data;
                CFG_TAG_NONCE1_SUCC64:    r_nt1_succ  <= i_cfg_data;
                CFG_NESTED_KEYSTREAM_ENC: r_nested_ks <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic            chain_en;
    logic [N_CELLS:0] s_valid;
    t_stage          s_data [0:N_CELLS];

    // Advance the whole chain together; hold while the skid stage is full
    assign o_in_ready = chain_en;

    // Entry: odd/even halves trimmed to 24 bits; keep the all-zero flag
    assign s_valid[0] = i_in_valid;
    assign s_data[0]  = '{nz: |{i_cand_odd, i_cand_even},
                          o:  i_cand_odd[23:0],
                          e:  i_cand_even[23:0],
                          ko: '0,
                          ke: '0,
                          ks: '0};

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        localparam int unsigned W = k / STEPS_PER_WORD;
        localparam int unsigned J = k % STEPS_PER_WORD;
        localparam logic [4:0] BI_BACK = 5'(31 - J) ^ 5'd24;
        localparam logic [4:0] BI_FWD  = 5'(J) ^ 5'd24;

        logic [31:0] word;
        t_cell_ctl   ctl;

        // Per-cell duty, fixed by position and the attack mode
        always_comb begin
            word = '0;
            ctl  = '{op: OP_HOLD, in_bit: 1'b0, fb: 1'b0, keep: 1'b0, ks_en: 1'b0};
            if (r_mode == MODE_TWO_SESSION) begin
                unique case (W)
                    0:       word = '0;
                    1:       word = r_rn0_enc;
                    2:       word = r_nt0_x;
                    3:       word = r_nt1_x;
                    4:       word = r_rn1_enc;
                    default: word = '0;
                endcase
                ctl.op     = (W < 3) ? OP_BACK : OP_FWD;
                ctl.fb     = (W == 1) || (W == 4);
                ctl.keep   = (k == 3 * STEPS_PER_WORD - 1);
                ctl.ks_en  = (W == N_WORDS - 1);
            end else begin
                word       = (W == 0) ? r_nt1_x : r_nt0_x;
                ctl.op     = (W == 0) ? OP_BACK : ((W == 1) ? OP_FWD : OP_HOLD);
                ctl.keep   = (k == STEPS_PER_WORD - 1);
                ctl.ks_en  = (W == 1);
            end
            ctl.in_bit = (ctl.op == OP_BACK) ? word[BI_BACK] : word[BI_FWD];
        end

        c1sc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_valid (s_valid[k]),
            .i_data  (s_data[k]),
            .i_ctl   (ctl),
            .o_valid (s_valid[k + 1]),
            .o_data  (s_data[k + 1])
        );
    end

    // ------------------------------------------------------------------
    // Compare at the end of the chain
    // ------------------------------------------------------------------
    t_stage      tail;
    logic [31:0] ks_word;
    logic        hit;
    t_result     res;

    assign tail    = s_data[N_CELLS];
    assign ks_word = ks_order(tail.ks);

    always_comb begin
        if (r_mode == MODE_TWO_SESSION) begin
            hit = tail.nz && (r_ra1_enc == (ks_word ^ r_nt1_succ));
        end else begin
            hit = tail.nz && (r_nested_ks == ks_word);
        end
        res.match = hit;
        res.key   = hit ? pack_key(tail.ko, tail.ke) : '0;
    end

    t_result out_res;

    c1sc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (chain_en && s_valid[N_CELLS]),
        .i_result (res),
        .o_room   (chain_en),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_match     = out_res.match;
    assign o_key_value = out_res.key;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The chain only freezes while a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("chain stalled with no result waiting");

    // A result without a match carries a zero key
    a_nomatch_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_match) |-> (o_key_value == '0))
        else $error("non-zero key on a miss");

    // An all-zero candidate never matches at the chain end
    a_zero_never_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_valid[N_CELLS] && !tail.nz) |-> !hit)
        else $error("zero candidate reported as match");

    // Reset empties the output stages
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output not empty after reset");

endmodule

// File: test/c1sc_key_monitor.sv
`timescale 1ns / 1ps
// Watches the candidate checker's channels, predicts the verdict and key for each request
// and compares every result in order. Depends on c1sc_pkg for constants and register codes.
module c1sc_key_monitor import c1sc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_cand_odd,
    input  logic [31:0] i_cand_even,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_match,
    input  logic [47:0] i_key_value,
    output int          o_outstanding,
    output int          o_errors
);

    typedef struct packed {
        logic [23:0] o;
        logic [23:0] e;
    } t_cipher_reg;

    typedef struct packed {
        logic        hit;
        logic [47:0] key;
    } t_verdict;

    t_verdict    due_keys[$];
    int          key_errors = 0;

    // shadow of the captured authentication set
    t_mode       mode_r;
    logic [31:0] rn0_enc;
    logic [31:0] nt0_x;
    logic [31:0] nt1_x;
    logic [31:0] rn1_enc;
    logic [31:0] ans1_enc;
    logic [31:0] nt1_succ;
    logic [31:0] nested_ks;

    function automatic logic filter_bit(input logic [23:0] v);
        logic [4:0] sel;
        sel = {NLF_A[v[3:0] + 5'd4], NLF_B[v[7:4] + 5'd3], NLF_C[v[11:8] + 5'd2],
               NLF_D[v[15:12] + 5'd1], NLF_E[v[19:16]]};
        return NLF_F[sel];
    endfunction

    function automatic t_cipher_reg unwind_word(input t_cipher_reg s, input logic [31:0] word,
                                                input logic fb);
        logic [23:0] t;
        logic        fbit;
        for (int i = 31; i >= 0; i--) begin
            t    = s.o;
            s.o  = s.e;
            s.e  = t;
            fbit = (filter_bit(s.o) & fb) ^ s.e[0];
            s.e  = s.e >> 1;
            fbit = fbit ^ (^(POLY_EVEN & s.e)) ^ (^(POLY_ODD & s.o)) ^ word[i ^ 24];
            s.e[23] = fbit;
        end
        return s;
    endfunction

    task automatic advance_word(inout t_cipher_reg s, input logic [31:0] word, input logic fb,
                                output logic [31:0] ks);
        logic        r;
        logic        fbit;
        logic [23:0] ne;
        ks = '0;
        for (int i = 0; i < 32; i++) begin
            r    = filter_bit(s.o);
            fbit = (r & fb) ^ (^(POLY_EVEN & s.e)) ^ (^(POLY_ODD & s.o)) ^ word[i ^ 24];
            ne   = {s.e[22:0], fbit};
            s.e  = s.o;
            s.o  = ne;
            ks[i ^ 24] = r;
        end
    endtask

    task automatic recover_key(input logic [31:0] odd, input logic [31:0] even,
                               output t_verdict v);
        t_cipher_reg s;
        t_cipher_reg kept;
        logic [31:0] ks;
        logic        hit;
        v = '0;
        if ({odd, even} != 64'd0) begin
            s.o = odd[23:0];
            s.e = even[23:0];
            if (mode_r == MODE_TWO_SESSION) begin
                s = unwind_word(s, 32'd0, 1'b0);
                s = unwind_word(s, rn0_enc, 1'b1);
                s = unwind_word(s, nt0_x, 1'b0);
                kept = s;
                advance_word(s, nt1_x, 1'b0, ks);
                advance_word(s, rn1_enc, 1'b1, ks);
                advance_word(s, 32'd0, 1'b0, ks);
                hit = ((ks ^ nt1_succ) == ans1_enc);
            end else begin
                s = unwind_word(s, nt1_x, 1'b0);
                kept = s;
                advance_word(s, nt0_x, 1'b0, ks);
                hit = (ks == nested_ks);
            end
            if (hit) begin
                v.hit = 1'b1;
                // odd/even bit pairs, highest pair first, bit index swizzled by 3
                for (int i = 23; i >= 0; i--) begin
                    v.key = {v.key[45:0], kept.o[i ^ 3], kept.e[i ^ 3]};
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            mode_r    = MODE_TWO_SESSION;
            rn0_enc   = '0;
            nt0_x     = '0;
            nt1_x     = '0;
            rn1_enc   = '0;
            ans1_enc  = '0;
            nt1_succ  = '0;
            nested_ks = '0;
            due_keys.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_keys.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    key_errors++;
                end else begin
                    want = due_keys.pop_front();
                    if (i_match !== want.hit) begin
                        $error("match: expected %0d, got %0d", want.hit, i_match);
                        key_errors++;
                    end
                    if (i_key_value !== want.key) begin
                        $error("key_value: expected %012h, got %012h", want.key, i_key_value);
                        key_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                recover_key(i_cand_odd, i_cand_even, want);
                due_keys.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ATTACK_MODE:          mode_r    = t_mode'(i_cfg_data[0]);
                    CFG_READER_NONCE0_ENC:    rn0_enc   = i_cfg_data;
                    CFG_UID_XOR_TAG_NONCE0:   nt0_x     = i_cfg_data;
                    CFG_UID_XOR_TAG_NONCE1:   nt1_x     = i_cfg_data;
                    CFG_READER_NONCE1_ENC:    rn1_enc   = i_cfg_data;
                    CFG_READER_ANSWER1_ENC:   ans1_enc  = i_cfg_data;
                    CFG_TAG_NONCE1_SUCC64:    nt1_succ  = i_cfg_data;
                    CFG_NESTED_KEYSTREAM_ENC: nested_ks = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= due_keys.size();
        o_errors      <= key_errors;
    end

endmodule

// File: test/crypto1_candidate_state_checker_unit_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the Crypto1 candidate-state checker.
// Depends on c1sc_pkg, the block under test and c1sc_key_monitor.
module crypto1_candidate_state_checker_unit_tb;
    import c1sc_pkg::*;

    localparam int DRAIN_CYCLES    = 220;     // pipeline is 193 deep, leave some margin
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 155;

    typedef struct packed {
        logic [23:0] o;
        logic [23:0] e;
    } t_cipher_reg;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_cand_odd  = '0;
    logic [31:0] i_cand_even = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_match;
    logic [47:0] o_key_value;

    int          pending;
    int          fails;
    int          cycles = 0;
    logic        quiet  = 1'b0;     // no idling on either side once set

    // register plan for the next phase, and the candidate that must hit under it
    logic [31:0] plan [8];
    t_cipher_reg target;

    crypto1_candidate_state_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cand_odd  (i_cand_odd),
        .i_cand_even (i_cand_even),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_match     (o_match),
        .o_key_value (o_key_value)
    );

    c1sc_key_monitor u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cand_odd    (i_cand_odd),
        .i_cand_even   (i_cand_even),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_match       (o_match),
        .i_key_value   (o_key_value),
        .o_outstanding (pending),
        .o_errors      (fails)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("crypto1_candidate_state_checker_unit verification failed");
            $finish;
        end
    end

    // Receiver side: mostly ready, with occasional stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Filter output used to build matching candidates
    function automatic logic keystream_bit(input logic [23:0] v);
        logic [4:0] sel;
        sel = {NLF_A[v[3:0] + 5'd4], NLF_B[v[7:4] + 5'd3], NLF_C[v[11:8] + 5'd2],
               NLF_D[v[15:12] + 5'd1], NLF_E[v[19:16]]};
        return NLF_F[sel];
    endfunction

    // Run the cipher forward over one word; ks collects the filter outputs
    task automatic roll_fwd(inout t_cipher_reg s, input logic [31:0] word, input logic fb,
                            output logic [31:0] ks);
        logic r;
        logic fbit;
        ks = '0;
        for (int i = 0; i < 32; i++) begin
            r    = keystream_bit(s.o);
            fbit = (r & fb) ^ (^(POLY_EVEN & s.e)) ^ (^(POLY_ODD & s.o)) ^ word[i ^ 24];
            ks[i ^ 24] = r;
            {s.o, s.e} = {s.e[22:0], fbit, s.o};
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Fix the observed word so that 'kept' is the recovered key, derive the candidate that
    // unwinds to it, then drain the pipeline and write every register
    task automatic arm_phase(input t_mode mode, input t_cipher_reg kept);
        t_cipher_reg s;
        logic [31:0] ks;
        i_in_valid <= 1'b0;
        plan[CFG_ATTACK_MODE] = {31'd0, mode};
        s = kept;
        if (mode == MODE_TWO_SESSION) begin
            roll_fwd(s, plan[CFG_UID_XOR_TAG_NONCE1], 1'b0, ks);
            roll_fwd(s, plan[CFG_READER_NONCE1_ENC], 1'b1, ks);
            roll_fwd(s, 32'd0, 1'b0, ks);
            plan[CFG_READER_ANSWER1_ENC] = ks ^ plan[CFG_TAG_NONCE1_SUCC64];
            s = kept;
            roll_fwd(s, plan[CFG_UID_XOR_TAG_NONCE0], 1'b0, ks);
            roll_fwd(s, plan[CFG_READER_NONCE0_ENC], 1'b1, ks);
            roll_fwd(s, 32'd0, 1'b0, ks);
        end else begin
            roll_fwd(s, plan[CFG_UID_XOR_TAG_NONCE0], 1'b0, ks);
            plan[CFG_NESTED_KEYSTREAM_ENC] = ks;
            s = kept;
            roll_fwd(s, plan[CFG_UID_XOR_TAG_NONCE1], 1'b0, ks);
        end
        target = s;
        // hold the sender until every outstanding result has been taken
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int r = 0; r < 8; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(r);
            i_cfg_data  <= plan[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Present one request and hold it until accepted; valid stays up on exit
    task automatic offer(input logic [31:0] odd, input logic [31:0] even);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cand_odd  <= odd;
        i_cand_even <= even;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic offer_around_target();
        t_cipher_reg c;
        c = target;
        offer({8'h00, c.o}, {8'h00, c.e});
        offer({8'hFF, c.o}, {8'hFF, c.e});
        c.e[$urandom_range(0, 23)] ^= 1'b1;
        offer({8'h00, c.o}, {8'h00, c.e});
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Random request: the hitting candidate with junk upper bytes, plus near misses,
    // zero states and plain noise
    task automatic offer_mix();
        int          pick;
        t_cipher_reg c;
        logic [7:0]  hi_o;
        logic [7:0]  hi_e;
        pick = $urandom_range(0, 99);
        c    = target;
        hi_o = 8'($urandom);
        hi_e = 8'($urandom);
        if (pick < 35) begin
            // hitting candidate as is
        end else if (pick < 45) begin
            if (pick[0]) c.o[$urandom_range(0, 23)] ^= 1'b1;
            else         c.e[$urandom_range(0, 23)] ^= 1'b1;
        end else if (pick < 50) begin
            c = '0;
            if (hi_o == 8'd0) hi_e = 8'h01;
        end else if (pick < 53) begin
            c    = '0;
            hi_o = 8'd0;
            hi_e = 8'd0;
        end else begin
            c.o = 24'($urandom);
            c.e = 24'($urandom);
        end
        offer({hi_o, c.o}, {hi_e, c.e});
    endtask

    initial begin
        t_cipher_reg k;
        for (int r = 0; r < 8; r++) plan[r] = '0;
        target = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a zero state with upper bits set unwinds to zero and hits with a
        // zero key, whereas the all-zero candidate must never hit
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'hFF00_0000, 32'h0000_0000);
        offer(32'h0000_0000, 32'h0100_0000);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(32'h00FF_FFFF, 32'h0000_0000);
        offer(32'h0000_0001, 32'h0080_0000);

        // Nested check with an all-zero capture
        arm_phase(MODE_NESTED, '0);
        offer(32'h0000_0000, 32'h0000_0000);
        offer(32'h8000_0000, 32'h8000_0000);
        offer(32'hFFFF_FFFF, 32'h0000_0000);
        offer($urandom, $urandom);

        // Extremes: every capture word all ones, bar the one that arm_phase derives
        for (int r = 1; r < 8; r++) plan[r] = 32'hFFFF_FFFF;
        arm_phase(MODE_TWO_SESSION, {24'hFFFFFF, 24'hFFFFFF});
        offer_around_target();
        for (int r = 1; r < 8; r++) plan[r] = 32'hFFFF_FFFF;
        arm_phase(MODE_NESTED, {24'h000001, 24'h800000});
        offer_around_target();

        // Random captures, alternating modes; the last two phases run without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            quiet = (p >= RAND_PHASES - 2);
            for (int r = 1; r < 8; r++) plan[r] = pick_word();
            k.o = 24'($urandom);
            k.e = 24'($urandom);
            arm_phase(t_mode'(p % 2), k);
            repeat (ITEMS_PER_PHASE) offer_mix();
        end

        // Drop valid, let every result drain, then give the verdict
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("crypto1_candidate_state_checker_unit verification clean");
        end else begin
            $display("crypto1_candidate_state_checker_unit verification failed");
        end
        $finish;
    end

endmodule

// File: crypto1_candidate_state_checker_unit.f
src/c1sc_pkg.sv
src/c1sc_cell.sv
src/c1sc_out.sv
src/crypto1_candidate_state_checker_unit.sv
test/c1sc_key_monitor.sv
test/crypto1_candidate_state_checker_unit_tb.sv
